### rtl/core/tllru_pkg.sv
// ----------------------------------------------------------------------------
// tllru_pkg
// shared constants and types for the two-level lru miss counter
// ----------------------------------------------------------------------------
`default_nettype none
package tllru_pkg;

  localparam int unsigned LineBytesDef = 64;
  localparam int unsigned L1SetsDef    = 8;
  localparam int unsigned L1WaysDef    = 2;
  localparam int unsigned L2SetsDef    = 64;
  localparam int unsigned L2WaysDef    = 8;
  localparam int unsigned AddrBitsDef  = 48;

  localparam int unsigned FieldAddrW = 48;
  localparam int unsigned CountW     = 32;

  localparam logic CmdAccess = 1'b0;
  localparam logic CmdClear  = 1'b1;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_L1_LOOK,
    ST_L2_LOOK,
    ST_RESULT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic sweep;
    logic l1_update;
    logic l2_update;
    logic count_clear;
    logic out_load;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_clear;
    logic l1_hit;
    logic sweep_done;
  } stat_t;

endpackage : tllru_pkg
`default_nettype wire

### rtl/core/tllru_if.sv
// ----------------------------------------------------------------------------
// tllru_in_if / tllru_out_if
// valid/ready channels carrying access items and results
// ----------------------------------------------------------------------------
`default_nettype none
interface tllru_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [tllru_pkg::FieldAddrW-1:0]  byte_address;
  modport source (output valid, output cmd, output byte_address, input ready);
  modport sink   (input valid, input cmd, input byte_address, output ready);
endinterface

interface tllru_out_if;
  logic                          valid;
  logic                          ready;
  logic                          l1_hit;
  logic                          l2_hit;
  logic [tllru_pkg::CountW-1:0]  l1_miss_total;
  logic [tllru_pkg::CountW-1:0]  l2_miss_total;
  modport source (output valid, output l1_hit, output l2_hit, output l1_miss_total,
                  output l2_miss_total, input ready);
  modport sink   (input valid, input l1_hit, input l2_hit, input l1_miss_total,
                  input l2_miss_total, output ready);
endinterface
`default_nettype wire

### rtl/core/tllru_ctrl.sv
// ----------------------------------------------------------------------------
// tllru_ctrl
// sequencer: clearing sweep, l1 lookup, l2 lookup, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
module tllru_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_busy_i,
  input  wire tllru_pkg::stat_t stat_i,
  output tllru_pkg::ctrl_t      ctrl_o
);

  tllru_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tllru_pkg::ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tllru_pkg::ST_SWEEP: begin
        if (stat_i.sweep_done) state_d = tllru_pkg::ST_IDLE;
      end
      tllru_pkg::ST_IDLE: begin
        if (in_valid_i && !out_busy_i) state_d = tllru_pkg::ST_L1_LOOK;
      end
      tllru_pkg::ST_L1_LOOK: begin
        if (stat_i.is_clear) state_d = tllru_pkg::ST_SWEEP;
        else if (stat_i.l1_hit) state_d = tllru_pkg::ST_RESULT;
        else state_d = tllru_pkg::ST_L2_LOOK;
      end
      tllru_pkg::ST_L2_LOOK: state_d = tllru_pkg::ST_RESULT;
      tllru_pkg::ST_RESULT: begin
        if (!out_busy_i) state_d = tllru_pkg::ST_IDLE;
      end
      default: state_d = tllru_pkg::ST_SWEEP;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tllru_pkg::ST_SWEEP: ctrl_o.sweep = 1'b1;
      tllru_pkg::ST_IDLE: begin
        // the result register doubles as the live state, so wait for it to drain
        in_ready_o       = !out_busy_i;
        ctrl_o.load_item = in_valid_i && !out_busy_i;
      end
      tllru_pkg::ST_L1_LOOK: begin
        if (stat_i.is_clear) begin
          // clear result leaves now, the sweep follows
          ctrl_o.count_clear = !out_busy_i;
          ctrl_o.out_load    = !out_busy_i;
        end else begin
          ctrl_o.l1_update = 1'b1;
        end
      end
      tllru_pkg::ST_L2_LOOK: ctrl_o.l2_update = 1'b1;
      tllru_pkg::ST_RESULT:  ctrl_o.out_load  = !out_busy_i;
      default: ctrl_o = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/tllru_level.sv
// ----------------------------------------------------------------------------
// tllru_level
// one set-associative level: tag, valid and rank memories with true lru
// ----------------------------------------------------------------------------
`default_nettype none
module tllru_level #(
  parameter int unsigned Sets  = 8,
  parameter int unsigned Ways  = 2,
  parameter int unsigned LineW = 42
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_i,
  input  wire logic [LineW-1:0] line_i,
  input  wire logic             upd_i,
  input  wire logic             sweep_i,
  output logic                  hit_o,
  output logic                  sweep_done_o
);

  localparam int unsigned SetW  = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned IdxW  = (Sets > 1) ? $clog2(Sets) : 0;
  localparam int unsigned TagW  = LineW - IdxW;
  localparam int unsigned RankW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned WayW  = (Ways > 1) ? $clog2(Ways) : 1;

  typedef logic [Ways-1:0][TagW-1:0]  tag_row_t;
  typedef logic [Ways-1:0][RankW-1:0] rank_row_t;

  tag_row_t         tag_mem   [Sets];
  logic [Ways-1:0]  valid_mem [Sets];
  rank_row_t        rank_mem  [Sets];

  tag_row_t        tag_rd_q;
  logic [Ways-1:0] valid_rd_q;
  rank_row_t       rank_rd_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic [SetW-1:0] sweep_q;

  logic [SetW-1:0] set_w;
  logic [TagW-1:0] tag_w;

  if (Sets > 1) begin : g_idx
    assign set_w = line_i[SetW-1:0];
    assign tag_w = line_i[LineW-1:IdxW];
  end else begin : g_noidx
    assign set_w = '0;
    assign tag_w = line_i;
  end

  // lookup on the registered row
  logic [Ways-1:0] hit_vec, empty_vec, lru_vec;
  logic [WayW-1:0] pick;
  logic            hit;
  logic [RankW-1:0] old_rank;
  logic [Ways-1:0]  valid_nx;
  rank_row_t        rank_nx;
  tag_row_t         tag_nx;

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      hit_vec[w]   = valid_rd_q[w] && (tag_rd_q[w] == tag_q);
      empty_vec[w] = !valid_rd_q[w];
      lru_vec[w]   = (rank_rd_q[w] == RankW'(Ways - 1));
    end
    hit  = |hit_vec;
    pick = '0;
    if (hit) begin
      for (int w = Ways - 1; w >= 0; w--) if (hit_vec[w]) pick = WayW'(w);
    end else if (|empty_vec) begin
      for (int w = Ways - 1; w >= 0; w--) if (empty_vec[w]) pick = WayW'(w);
    end else begin
      for (int w = Ways - 1; w >= 0; w--) if (lru_vec[w]) pick = WayW'(w);
    end
    old_rank = valid_rd_q[pick] ? rank_rd_q[pick] : RankW'(Ways - 1);
    valid_nx = valid_rd_q;
    rank_nx  = rank_rd_q;
    tag_nx   = tag_rd_q;
    for (int w = 0; w < Ways; w++) begin
      if (WayW'(w) != pick && valid_rd_q[w] && rank_rd_q[w] < old_rank) begin
        rank_nx[w] = rank_rd_q[w] + 1'b1;
      end
    end
    rank_nx[pick]  = '0;
    valid_nx[pick] = 1'b1;
    tag_nx[pick]   = tag_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      tag_rd_q   <= tag_mem[set_w];
      valid_rd_q <= valid_mem[set_w];
      rank_rd_q  <= rank_mem[set_w];
      set_q      <= set_w;
      tag_q      <= tag_w;
    end
    if (sweep_i) begin
      valid_mem[sweep_q] <= '0;
      rank_mem[sweep_q]  <= '0;
    end else if (upd_i) begin
      valid_mem[set_q] <= valid_nx;
      rank_mem[set_q]  <= rank_nx;
      tag_mem[set_q]   <= tag_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (sweep_i) begin
      sweep_q <= sweep_done_o ? '0 : sweep_q + 1'b1;
    end
  end

  assign sweep_done_o = (sweep_q == SetW'(Sets - 1));
  assign hit_o        = hit;

endmodule
`default_nettype wire

### rtl/core/tllru_dp.sv
// ----------------------------------------------------------------------------
// tllru_dp
// datapath: item register, both cache levels, miss counters, result register
// ----------------------------------------------------------------------------
`default_nettype none
module tllru_dp #(
  parameter int unsigned LineBytes = tllru_pkg::LineBytesDef,
  parameter int unsigned L1Sets    = tllru_pkg::L1SetsDef,
  parameter int unsigned L1Ways    = tllru_pkg::L1WaysDef,
  parameter int unsigned L2Sets    = tllru_pkg::L2SetsDef,
  parameter int unsigned L2Ways    = tllru_pkg::L2WaysDef,
  parameter int unsigned AddrBits  = tllru_pkg::AddrBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tllru_pkg::ctrl_t                    ctrl_i,
  output tllru_pkg::stat_t                         stat_o,
  input  wire logic                                cmd_i,
  input  wire logic [tllru_pkg::FieldAddrW-1:0]    byte_address_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic                                     out_busy_o,
  output logic                                     l1_hit_o,
  output logic                                     l2_hit_o,
  output logic [tllru_pkg::CountW-1:0]             l1_miss_total_o,
  output logic [tllru_pkg::CountW-1:0]             l2_miss_total_o
);

  localparam int unsigned EffW  = (AddrBits < tllru_pkg::FieldAddrW) ?
                                  AddrBits : tllru_pkg::FieldAddrW;
  localparam int unsigned OffW  = $clog2(LineBytes);
  localparam int unsigned LineW = EffW - OffW;
  localparam logic [tllru_pkg::CountW-1:0] CountMax = '1;

  logic [LineW-1:0] line_w;
  logic             clear_q, l1_hit_q, l2_hit_q, out_valid_q;
  logic             l1_hit_w, l2_hit_w, l1_done, l2_done;
  logic [tllru_pkg::CountW-1:0] l1_cnt_q, l2_cnt_q;

  assign line_w = byte_address_i[EffW-1:OffW];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) clear_q <= (cmd_i == tllru_pkg::CmdClear);
  end

  tllru_level #(.Sets(L1Sets), .Ways(L1Ways), .LineW(LineW)) u_l1 (
    .clk_i, .rst_ni, .rd_i(ctrl_i.load_item), .line_i(line_w),
    .upd_i(ctrl_i.l1_update), .sweep_i(ctrl_i.sweep),
    .hit_o(l1_hit_w), .sweep_done_o(l1_done)
  );

  // l2 reads alongside l1; its row is used only after an l1 miss
  tllru_level #(.Sets(L2Sets), .Ways(L2Ways), .LineW(LineW)) u_l2 (
    .clk_i, .rst_ni, .rd_i(ctrl_i.load_item), .line_i(line_w),
    .upd_i(ctrl_i.l2_update), .sweep_i(ctrl_i.sweep),
    .hit_o(l2_hit_w), .sweep_done_o(l2_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_cnt_q    <= '0;
      l2_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      l1_hit_q    <= 1'b0;
      l2_hit_q    <= 1'b0;
    end else begin
      if (ctrl_i.count_clear) begin
        l1_cnt_q <= '0;
        l2_cnt_q <= '0;
        l1_hit_q <= 1'b0;
        l2_hit_q <= 1'b0;
      end
      if (ctrl_i.l1_update) begin
        l1_hit_q <= l1_hit_w;
        l2_hit_q <= 1'b0;
        if (!l1_hit_w && l1_cnt_q != CountMax) l1_cnt_q <= l1_cnt_q + 1'b1;
      end
      if (ctrl_i.l2_update) begin
        l2_hit_q <= l2_hit_w;
        if (!l2_hit_w && l2_cnt_q != CountMax) l2_cnt_q <= l2_cnt_q + 1'b1;
      end
      if (ctrl_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.is_clear   = clear_q;
  assign stat_o.l1_hit     = l1_hit_w;
  assign stat_o.sweep_done = l1_done & l2_done;

  assign out_busy_o      = out_valid_q & !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign l1_hit_o        = l1_hit_q;
  assign l2_hit_o        = l2_hit_q;
  assign l1_miss_total_o = l1_cnt_q;
  assign l2_miss_total_o = l2_cnt_q;

endmodule
`default_nettype wire

### rtl/core/two_level_lru_cache_miss_counter_unit.sv
// ----------------------------------------------------------------------------
// two_level_lru_cache_miss_counter_unit
// two-level set-associative lru cache model counting l1 and l2 misses
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries cmd and byte_address; a clear command empties both levels
//   and zeroes the counters. out_ch returns one result per transaction: the
//   hit flags and the running saturating miss totals.
//   the set rows are read at acceptance, the l1 lookup state updates l1,
//   after an l1 miss the l2 lookup state updates l2, and the result state
//   registers the result.
//   the next transaction is taken once the previous result leaves, so the
//   block takes no new access before the previous one is through.
//   a clear loads its result in the l1 lookup state and then sweeps both
//   stores one set per cycle until every set of both is cleared,
//   during which no transaction is taken. the same sweep runs after reset.
//   when the receiver stalls the result holds in the output register and
//   the block takes no further transaction until it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module two_level_lru_cache_miss_counter_unit #(
  parameter int unsigned LineBytes = tllru_pkg::LineBytesDef,
  parameter int unsigned L1Sets    = tllru_pkg::L1SetsDef,
  parameter int unsigned L1Ways    = tllru_pkg::L1WaysDef,
  parameter int unsigned L2Sets    = tllru_pkg::L2SetsDef,
  parameter int unsigned L2Ways    = tllru_pkg::L2WaysDef,
  parameter int unsigned AddrBits  = tllru_pkg::AddrBitsDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  tllru_in_if.sink   in_ch,
  tllru_out_if.source out_ch
);

  tllru_pkg::ctrl_t ctrl;
  tllru_pkg::stat_t stat;
  logic             out_busy;

  tllru_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_busy_i(out_busy), .stat_i(stat), .ctrl_o(ctrl)
  );

  tllru_dp #(
    .LineBytes(LineBytes), .L1Sets(L1Sets), .L1Ways(L1Ways),
    .L2Sets(L2Sets), .L2Ways(L2Ways), .AddrBits(AddrBits)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i(in_ch.cmd), .byte_address_i(in_ch.byte_address),
    .out_ready_i(out_ch.ready), .out_valid_o(out_ch.valid), .out_busy_o(out_busy),
    .l1_hit_o(out_ch.l1_hit), .l2_hit_o(out_ch.l2_hit),
    .l1_miss_total_o(out_ch.l1_miss_total), .l2_miss_total_o(out_ch.l2_miss_total)
  );

endmodule
`default_nettype wire

### verif/tb_two_level_lru_cache_miss_counter_unit.sv
// ----------------------------------------------------------------------------
// tb_two_level_lru_cache_miss_counter_unit
// drives accesses and clears into the two-level lru miss counter, predicts
// hit flags and miss totals with a behavioural cache copy, checks each result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_two_level_lru_cache_miss_counter_unit;

  localparam int unsigned L1S = 8, L1W = 2, L2S = 64, L2W = 8;

  typedef struct {
    logic        l1_hit;
    logic        l2_hit;
    logic [31:0] l1_total;
    logic [31:0] l2_total;
  } outcome_t;

  class miss_scoreboard;
    bit          v1[L1S][L1W];
    logic [38:0] t1[L1S][L1W];
    int unsigned r1[L1S][L1W];
    bit          v2[L2S][L2W];
    logic [35:0] t2[L2S][L2W];
    int unsigned r2[L2S][L2W];
    logic [31:0] cnt1, cnt2;
    outcome_t    pending[$];
    int          errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (v1[s, w]) begin v1[s][w] = 0; r1[s][w] = 0; t1[s][w] = '0; end
      foreach (v2[s, w]) begin v2[s][w] = 0; r2[s][w] = 0; t2[s][w] = '0; end
      cnt1 = '0;
      cnt2 = '0;
    endfunction

    // true lru lookup with fill; rank 0 is most recent
    function bit touch_l1(int unsigned s, logic [38:0] tg);
      int unsigned pick, old;
      bit hit;
      pick = L1W;
      hit = 0;
      for (int w = 0; w < L1W; w++)
        if (pick == L1W && v1[s][w] && t1[s][w] == tg) begin pick = w; hit = 1; end
      for (int w = 0; w < L1W; w++) if (pick == L1W && !v1[s][w]) pick = w;
      if (pick == L1W) begin
        pick = 0;
        for (int w = L1W - 1; w >= 0; w--) if (r1[s][w] == L1W - 1) pick = w;
      end
      old = v1[s][pick] ? r1[s][pick] : L1W - 1;
      for (int w = 0; w < L1W; w++)
        if (w != pick && v1[s][w] && r1[s][w] < old) r1[s][w]++;
      r1[s][pick] = 0;
      v1[s][pick] = 1;
      t1[s][pick] = tg;
      return hit;
    endfunction

    function bit touch_l2(int unsigned s, logic [35:0] tg);
      int unsigned pick, old;
      bit hit;
      pick = L2W;
      hit = 0;
      for (int w = 0; w < L2W; w++)
        if (pick == L2W && v2[s][w] && t2[s][w] == tg) begin pick = w; hit = 1; end
      for (int w = 0; w < L2W; w++) if (pick == L2W && !v2[s][w]) pick = w;
      if (pick == L2W) begin
        pick = 0;
        for (int w = L2W - 1; w >= 0; w--) if (r2[s][w] == L2W - 1) pick = w;
      end
      old = v2[s][pick] ? r2[s][pick] : L2W - 1;
      for (int w = 0; w < L2W; w++)
        if (w != pick && v2[s][w] && r2[s][w] < old) r2[s][w]++;
      r2[s][pick] = 0;
      v2[s][pick] = 1;
      t2[s][pick] = tg;
      return hit;
    endfunction

    function void note_access(logic c, logic [47:0] addr);
      outcome_t o;
      logic [41:0] line;
      o.l1_hit = 0;
      o.l2_hit = 0;
      if (c == tllru_pkg::CmdClear) wipe();
      else begin
        line = addr[47:6];
        o.l1_hit = touch_l1(32'(line[2:0]), line[41:3]);
        if (!o.l1_hit) begin
          if (cnt1 != '1) cnt1++;
          o.l2_hit = touch_l2(32'(line[5:0]), line[41:6]);
          if (!o.l2_hit && cnt2 != '1) cnt2++;
        end
      end
      o.l1_total = cnt1;
      o.l2_total = cnt2;
      pending.push_back(o);
    endfunction

    function void check_result(logic h1, logic h2, logic [31:0] m1, logic [31:0] m2);
      outcome_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result h1=%b h2=%b m1=%0d m2=%0d", $time, h1, h2, m1, m2);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h1 !== e.l1_hit) begin
        $display("%0t: l1_hit exp %b got %b", $time, e.l1_hit, h1); errors++;
      end
      if (h2 !== e.l2_hit) begin
        $display("%0t: l2_hit exp %b got %b", $time, e.l2_hit, h2); errors++;
      end
      if (m1 !== e.l1_total) begin
        $display("%0t: l1_miss_total exp %0d got %0d", $time, e.l1_total, m1); errors++;
      end
      if (m2 !== e.l2_total) begin
        $display("%0t: l2_miss_total exp %0d got %0d", $time, e.l2_total, m2); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #6 clk_i = ~clk_i;

  tllru_in_if  in_ch();
  tllru_out_if out_ch();

  two_level_lru_cache_miss_counter_unit u_top (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_ch (in_ch.sink), .out_ch (out_ch.source)
  );

  miss_scoreboard sb = new();
  bit sending_done = 0;
  bit hold_off = 0;
  int burst_left = 0;
  logic [47:0] recent[$];

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = tllru_pkg::CmdAccess;
    in_ch.byte_address = '0;
    out_ch.ready = 0;
  end

  // sends one transaction, with burst/gap idling before it
  task automatic send_item(logic c, logic [47:0] addr);
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.cmd <= c;
    in_ch.byte_address <= addr;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_access(c, addr);
  endtask

  // build addresses that collide in a few sets so eviction gets exercised
  function automatic logic [47:0] pick_address();
    logic [47:0] a;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30 && recent.size() > 0) a = recent[$urandom_range(0, recent.size() - 1)];
    else if (k < 80) begin
      a = 48'({$urandom, $urandom});
      a[47:12] = {34'(0), 2'($urandom_range(0, 3))} ^ {36{k[0]}};
      a[8:6] = 3'($urandom_range(0, 1));
    end else a = 48'({$urandom, $urandom});
    a[5:0] = 6'($urandom);
    recent.push_back(a);
    if (recent.size() > 24) void'(recent.pop_front());
    return a;
  endfunction

  // receiver: own stall pattern, one long hold-off
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.l1_hit, out_ch.l2_hit, out_ch.l1_miss_total,
                      out_ch.l2_miss_total);
    if (hold_off) out_ch.ready <= 0;
    else out_ch.ready <= rst_ni && (($urandom_range(0, 9) < 7) || sending_done);
  end

  initial begin
    repeat (150) @(posedge clk_i);
    hold_off = 1;
    repeat (200) @(posedge clk_i);
    hold_off = 0;
  end

  initial begin
    logic [47:0] a;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, same-set conflicts, l2 fill, clear
    send_item(tllru_pkg::CmdAccess, 48'h0);
    send_item(tllru_pkg::CmdAccess, 48'h0);
    send_item(tllru_pkg::CmdAccess, '1);
    send_item(tllru_pkg::CmdAccess, '1);
    send_item(tllru_pkg::CmdAccess, 48'h200);
    send_item(tllru_pkg::CmdAccess, 48'h400);
    send_item(tllru_pkg::CmdAccess, 48'h0);
    send_item(tllru_pkg::CmdAccess, 48'h3F);
    for (int i = 1; i <= 9; i++) send_item(tllru_pkg::CmdAccess, 48'(i) << 12);
    send_item(tllru_pkg::CmdAccess, 48'h1000);
    send_item(tllru_pkg::CmdClear, '1);
    send_item(tllru_pkg::CmdAccess, 48'h0);
    send_item(tllru_pkg::CmdAccess, 48'hAAAA_AAAA_AAAA);
    send_item(tllru_pkg::CmdAccess, 48'h5555_5555_5555);
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 99) == 0)
        send_item(tllru_pkg::CmdClear, 48'({$urandom, $urandom}));
      else send_item(tllru_pkg::CmdAccess, pick_address());
    end
    in_ch.valid <= 0;
    sending_done = 1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/core/tllru_pkg.sv
rtl/core/tllru_if.sv
rtl/core/tllru_ctrl.sv
rtl/core/tllru_level.sv
rtl/core/tllru_dp.sv
rtl/core/two_level_lru_cache_miss_counter_unit.sv
verif/tb_two_level_lru_cache_miss_counter_unit.sv
